### hdl/fmr_pkg.sv
package fmr_pkg;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // Configuration register map
    typedef enum logic [1:0] {
        REG_FIND_PATTERN    = 2'd0,
        REG_FIND_LENGTH     = 2'd1,
        REG_REPLACE_PATTERN = 2'd2,
        REG_REPLACE_LENGTH  = 2'd3
    } cfg_reg_t;

    // Shared controls broadcast from the top level to every match cell
    typedef struct packed {
        logic       advance;   // text transaction accepted this cycle
        logic       discard;   // drop all partial matches on this advance
        logic       purge;     // find pattern or length rewritten: drop partial matches
        logic [7:0] in_byte;   // incoming text byte
    } fmr_cell_ctrl_t;

endpackage

### hdl/fmr_intf.sv
interface fmr_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface fmr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface fmr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/fmr_cell.sv
module fmr_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fmr_pkg::fmr_cell_ctrl_t ctrl,
    input  logic [7:0]             pat_byte,
    input  logic                   len_ok,
    input  logic                   prev_match,
    input  logic [7:0]             prev_byte,
    output logic                   match_next,
    output logic                   match_q,
    output logic [7:0]             byte_q
);
    import fmr_pkg::*;

    logic       match_reg;
    logic [7:0] byte_reg;

    // Prefix of this cell's length matches the stream tail after this byte
    assign match_next = prev_match && len_ok && (ctrl.in_byte == pat_byte);
    assign match_q    = match_reg;
    assign byte_q     = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.purge)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            match_reg <= ctrl.discard ? 1'b0 : match_next;
        end
    end

    // History byte, shifted one cell down per accepted byte
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            byte_reg <= prev_byte;
        end
    end

endmodule

### hdl/fmr_run_buf.sv
module fmr_run_buf #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [MAX_PATTERN*8-1:0]             push_bytes,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]     push_cnt,
    output logic                                 take,
    fmr_result_if.source                         result
);
    import fmr_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic [7:0]               act_byte_reg  [MAX_PATTERN];
    logic [7:0]               act_byte_next [MAX_PATTERN];
    logic [CW-1:0]            act_cnt_reg;
    logic [CW-1:0]            act_cnt_next;
    logic [MAX_PATTERN*8-1:0] pend_bytes_reg;
    logic [CW-1:0]            pend_cnt_reg;
    logic [CW-1:0]            pend_cnt_next;
    logic                     pend_load;
    logic                     pop;
    logic                     act_free;

    assign result.valid       = (act_cnt_reg != '0);
    assign result.out_byte    = act_byte_reg[0];
    assign result.last_of_run = (act_cnt_reg == CW'(1));

    assign pop      = result.valid && result.ready;
    // Active run is empty or hands over its final byte this cycle
    assign act_free = (act_cnt_reg == '0) || ((act_cnt_reg == CW'(1)) && result.ready);
    assign take     = (pend_cnt_reg == '0) || act_free;

    always_comb
    begin
        act_cnt_next  = act_cnt_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_load     = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            act_byte_next[i] = act_byte_reg[i];
        end

        if (act_free)
        begin
            if (pend_cnt_reg != '0)
            begin
                act_cnt_next = pend_cnt_reg;
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    act_byte_next[i] = pend_bytes_reg[8*i +: 8];
                end
                pend_cnt_next = push ? push_cnt : '0;
                pend_load     = push;
            end
            else if (push)
            begin
                act_cnt_next = push_cnt;
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    act_byte_next[i] = push_bytes[8*i +: 8];
                end
            end
            else
            begin
                act_cnt_next = '0;
            end
        end
        else
        begin
            if (pop)
            begin
                act_cnt_next = act_cnt_reg - CW'(1);
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                begin
                    act_byte_next[i] = act_byte_reg[i + 1];
                end
            end
            if (push)
            begin
                pend_cnt_next = push_cnt;
                pend_load     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_cnt_reg  <= '0;
            pend_cnt_reg <= '0;
        end
        else
        begin
            act_cnt_reg  <= act_cnt_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            act_byte_reg[i] <= act_byte_next[i];
        end
        if (pend_load)
        begin
            pend_bytes_reg <= push_bytes;
        end
    end

endmodule

### hdl/first_match_replace_per_line.sv
// Channel | Role   | Payload                        | Transaction when
// --------+--------+--------------------------------+-----------------------
// text    | sink   | in_byte[7:0], end_of_input     | text.valid & text.ready
// result  | source | out_byte[7:0], last_of_run     | result.valid & result.ready
// cfg     | sink   | index[1:0], data[63:0]         | cfg.valid & cfg.ready (always ready)
//
// One text byte is taken per cycle while text.ready is high; matching for it
// completes in the same cycle and its run of 0..MAX_PATTERN result bytes drains
// at one byte per cycle while result.ready is high. Throughput is 1 byte/cycle
// while each byte yields at most one result; longer runs can hold text.ready low.
// A pending-run slot lets one finished run wait while the next byte is taken.
// Reset (rst_n low, async) empties both run slots, clears partial matches and
// the line-replaced flag, and loads the config reset values. No clearing pass.
module first_match_replace_per_line #(
    parameter int MAX_PATTERN = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    fmr_text_if.sink     text,
    fmr_result_if.source result,
    fmr_cfg_if.sink      cfg
);
    import fmr_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Configuration registers
    logic [63:0] find_pattern_reg;
    logic [3:0]  find_length_reg;
    logic [63:0] replace_pattern_reg;
    logic [3:0]  replace_length_reg;
    cfg_reg_t    cfg_sel;
    logic        cfg_wr;
    logic        find_cfg_wr;

    // Line state
    logic        line_replaced_reg;
    logic        line_replaced_next;

    // Cell chain
    fmr_cell_ctrl_t          cell_ctrl;
    logic [MAX_PATTERN-1:0]  m_q;
    logic [MAX_PATTERN-1:0]  m_nx;
    logic [7:0]              hist_q [MAX_PATTERN];

    // Byte evaluation
    logic                    accept;
    logic                    take;
    logic [CW-1:0]           flen;
    logic [CW-1:0]           flen_m1;
    logic [CW-1:0]           rlen;
    logic [CW-1:0]           held_cnt;
    logic [CW-1:0]           keep_cnt;
    logic [CW-1:0]           hidx;
    logic                    bypass;
    logic                    full;
    logic                    flush;
    logic                    clear_m;
    logic [MAX_PATTERN*8-1:0] run_bytes;
    logic [CW-1:0]           run_cnt;
    logic                    push;

    // ------------------------------------------------------------------
    // Configuration port: always ready, unknown codes cannot occur in 2 bits
    // ------------------------------------------------------------------
    assign cfg.ready   = 1'b1;
    assign cfg_wr      = cfg.valid && cfg.ready;
    assign cfg_sel     = cfg_reg_t'(cfg.index);
    // Rewriting the find term throws away held candidate bytes
    assign find_cfg_wr = cfg_wr && ((cfg_sel == REG_FIND_PATTERN) ||
                                    (cfg_sel == REG_FIND_LENGTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_pattern_reg    <= '0;
            find_length_reg     <= 4'd1;
            replace_pattern_reg <= '0;
            replace_length_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_FIND_PATTERN:    find_pattern_reg    <= cfg.data;
                REG_FIND_LENGTH:     find_length_reg     <= cfg.data[3:0];
                REG_REPLACE_PATTERN: replace_pattern_reg <= cfg.data;
                REG_REPLACE_LENGTH:  replace_length_reg  <= cfg.data[3:0];
            endcase
        end
    end

    // Lengths above the cell count saturate
    assign flen = (find_length_reg > 4'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
                                                      : find_length_reg[CW-1:0];
    assign rlen = (replace_length_reg > 4'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
                                                         : replace_length_reg[CW-1:0];
    assign flen_m1 = flen - CW'(1);

    // ------------------------------------------------------------------
    // Match chain: cell k tracks "tail of length k+1 equals pattern prefix"
    // and holds the byte k+1 positions back. Held bytes are the stream tail.
    // ------------------------------------------------------------------
    assign accept = text.valid && text.ready;
    assign text.ready = take;

    assign cell_ctrl.advance = accept;
    assign cell_ctrl.discard = clear_m;
    assign cell_ctrl.purge   = find_cfg_wr;
    assign cell_ctrl.in_byte = text.in_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic       prev_match;
        logic [7:0] prev_byte;

        if (k == 0)
        begin : g_head
            assign prev_match = 1'b1;   // empty prefix always matches
            assign prev_byte  = text.in_byte;
        end
        else
        begin : g_body
            assign prev_match = m_q[k-1];
            assign prev_byte  = hist_q[k-1];
        end

        fmr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .pat_byte   (find_pattern_reg[8*k +: 8]),
            .len_ok     (CW'(k + 1) <= flen),
            .prev_match (prev_match),
            .prev_byte  (prev_byte),
            .match_next (m_nx[k]),
            .match_q    (m_q[k]),
            .byte_q     (hist_q[k])
        );
    end

    // ------------------------------------------------------------------
    // Per-byte decision and run assembly
    // ------------------------------------------------------------------
    always_comb
    begin
        // Held count = longest live partial match
        held_cnt = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (m_q[i])
            begin
                held_cnt = CW'(i + 1);
            end
        end

        // Bytes still held after this one, if no match and no flush
        keep_cnt = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (m_nx[i] && (CW'(i + 1) < flen))
            begin
                keep_cnt = CW'(i + 1);
            end
        end

        bypass = line_replaced_reg || (flen == '0);
        full   = (flen != '0) && m_nx[flen_m1[IW-1:0]];
        flush  = (text.in_byte == NEWLINE_BYTE) || text.end_of_input;

        clear_m = bypass || full || flush;

        if (flush)
        begin
            line_replaced_next = 1'b0;
        end
        else if (!bypass && full)
        begin
            line_replaced_next = 1'b1;
        end
        else
        begin
            line_replaced_next = line_replaced_reg;
        end

        // Candidate window, oldest first: held bytes then the new byte
        hidx = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            hidx = held_cnt - CW'(i) - CW'(1);
            if (!bypass && full)
            begin
                run_bytes[8*i +: 8] = replace_pattern_reg[8*i +: 8];
            end
            else if (CW'(i) < held_cnt)
            begin
                run_bytes[8*i +: 8] = hist_q[hidx[IW-1:0]];
            end
            else
            begin
                run_bytes[8*i +: 8] = text.in_byte;
            end
        end

        if (!bypass && full)
        begin
            run_cnt = rlen;
        end
        else if (bypass || flush)
        begin
            run_cnt = held_cnt + CW'(1);
        end
        else
        begin
            run_cnt = held_cnt + CW'(1) - keep_cnt;
        end
    end

    assign push = accept && (run_cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_replaced_reg <= 1'b0;
        end
        else if (accept)
        begin
            line_replaced_reg <= line_replaced_next;
        end
    end

    // Output staging: active run shifter plus one pending run
    fmr_run_buf #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_run_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_bytes (run_bytes),
        .push_cnt   (run_cnt),
        .take       (take),
        .result     (result)
    );

endmodule

### hdl/fmr_checker.sv
module fmr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       text_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] result_out_byte,
    input logic       result_last_of_run,
    input logic       cfg_valid,
    input logic       cfg_ready
);
    import fmr_pkg::*;

    // Held result stays put until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_out_byte) && $stable(result_last_of_run))
    else $error("result changed while stalled");

    // A run does not break before its last byte
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result_last_of_run |=> result_valid)
    else $error("run ended without last_of_run");

    // Text is only held off while output data is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> result_valid)
    else $error("text stalled with no pending output");

    // Config port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind first_match_replace_per_line fmr_checker u_fmr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .text_ready         (text.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_out_byte    (result.out_byte),
    .result_last_of_run (result.last_of_run),
    .cfg_valid          (cfg.valid),
    .cfg_ready          (cfg.ready)
);
